@@ hdl/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC   = DATA_W - 2;
  localparam int A_W    = DATA_W + 3;
  localparam int D_W    = DATA_W + 1;
  localparam int MAG_W  = DATA_W + 1;
  localparam int RAD_W  = 2 * DATA_W;
  localparam int ROOT_W = DATA_W;
  localparam int REM_W  = ROOT_W + 4;
  localparam int SQRT_N = ROOT_W;
  localparam int NUM_W  = 2 * DATA_W;
  localparam int DIV_W  = ROOT_W + 1;
  localparam int Q_W    = DATA_W;
  localparam int DIV_N  = Q_W;

  typedef enum logic [1:0] {
    ROLE_ROOT,
    ROLE_D0,
    ROLE_D1,
    ROLE_D2
  } role_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
  } in_data_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic                     degenerate;
  } out_data_t;

  typedef struct packed {
    logic                          degen;
    logic [2:0]                    neg;
    logic [2:0][MAG_W-1:0]         mag;
    role_t [3:0]                   role;
  } side_t;

endpackage

@@ hdl/rmq_if.sv @@
// Valid/ready channel interfaces for matrix input and quaternion output.
interface rmq_in_if;
  import rmq_pkg::*;
  logic     valid;
  logic     ready;
  in_data_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic      valid;
  logic      ready;
  out_data_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/rmq_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rmq_pkg::RAD_W-1:0]  rad,
  output logic [rmq_pkg::ROOT_W-1:0] root
);
  import rmq_pkg::*;

  logic [RAD_W-1:0]  rad_r  [SQRT_N];
  logic [REM_W-1:0]  rem_r  [SQRT_N];
  logic [ROOT_W-1:0] root_r [SQRT_N];

  for (genvar t = 0; t < SQRT_N; t++) begin : g_stage
    logic [RAD_W-1:0]  rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [REM_W-1:0]  tr;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (t == 0) begin : g_first
      assign rad_p  = rad;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_r[t-1];
      assign rem_p  = rem_r[t-1];
      assign root_p = root_r[t-1];
    end

    always_comb begin
      tr    = REM_W'({rem_p, rad_p[2*(SQRT_N-1-t) +: 2]});
      trial = REM_W'({root_p, 2'b01});
      if (tr >= trial) begin
        rem_nxt  = tr - trial;
        root_nxt = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = tr;
        root_nxt = {root_p[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[t]  <= rad_p;
        rem_r[t]  <= rem_nxt;
        root_r[t] <= root_nxt;
      end
    end
  end

  assign root = root_r[SQRT_N-1];

endmodule

@@ hdl/rmq_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rmq_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rmq_pkg::NUM_W-1:0] num,
  input  logic [rmq_pkg::DIV_W-1:0] div,
  output logic [rmq_pkg::Q_W-1:0]   quo,
  output logic                      ovf
);
  import rmq_pkg::*;

  logic [NUM_W-1:0] num_r [DIV_N];
  logic [DIV_W-1:0] div_r [DIV_N];
  logic [DIV_W-1:0] rem_r [DIV_N];
  logic [Q_W-1:0]   q_r   [DIV_N];
  logic             ovf_r [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_stage
    logic [NUM_W-1:0] num_p;
    logic [DIV_W-1:0] div_p;
    logic [DIV_W-1:0] rem_p;
    logic [Q_W-1:0]   q_p;
    logic             ovf_p;
    logic [DIV_W:0]   tr;
    logic [DIV_W-1:0] rem_nxt;
    logic [Q_W-1:0]   q_nxt;

    if (k == 0) begin : g_first
      assign num_p = num;
      assign div_p = div;
      assign rem_p = DIV_W'(num[NUM_W-1:Q_W]);
      assign q_p   = '0;
      assign ovf_p = {1'b0, num} >= {div, {Q_W{1'b0}}};
    end else begin : g_next
      assign num_p = num_r[k-1];
      assign div_p = div_r[k-1];
      assign rem_p = rem_r[k-1];
      assign q_p   = q_r[k-1];
      assign ovf_p = ovf_r[k-1];
    end

    always_comb begin
      tr = {rem_p, num_p[Q_W-1-k]};
      if (tr >= {1'b0, div_p}) begin
        rem_nxt = DIV_W'(tr - {1'b0, div_p});
        q_nxt   = {q_p[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIV_W'(tr);
        q_nxt   = {q_p[Q_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_p;
        div_r[k] <= div_p;
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_p;
      end
    end
  end

  assign quo = q_r[DIV_N-1];
  assign ovf = ovf_r[DIV_N-1];

endmodule

@@ hdl/rotation_matrix_to_quaternion_top.sv @@
// Rotation matrix (Q2.14) to unit quaternion converter, fully pipelined.
// Accepts one matrix per clock unless the output stalls, and returns one quaternion per matrix, in order.
// Two front-end stages pick the branch and form the root argument and the
// off-diagonal sums, a 16-stage root pipeline and three 16-stage divider
// pipelines produce one bit per stage, and the last stage saturates and
// routes the components. The whole pipeline holds while the output item
// waits; degenerate input gives zeros.
module rotation_matrix_to_quaternion_top (
  input  logic  clk,
  input  logic  rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  import rmq_pkg::*;

  function automatic logic signed [DATA_W-1:0] sat_q(input logic [Q_W-1:0] q,
                                                      input logic ovf,
                                                      input logic neg);
    logic signed [DATA_W:0] v;
    begin
      v = signed'({1'b0, q});
      if (!neg) begin
        if (ovf || q[Q_W-1]) sat_q = {1'b0, {(DATA_W-1){1'b1}}};
        else                 sat_q = DATA_W'(v);
      end else begin
        if (ovf || (q[Q_W-1] && (q[Q_W-2:0] != '0))) sat_q = {1'b1, {(DATA_W-1){1'b0}}};
        else                                         sat_q = DATA_W'(-v);
      end
    end
  endfunction

  logic out_valid_r;
  logic adv;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1
  logic                   s1_valid_r;
  in_data_t               s1_m_r;
  logic signed [A_W-1:0]  s1_trace_r;
  logic [1:0]             s1_i_r;
  logic signed [A_W-1:0]  trace_c;
  logic [1:0]             i_c;
  logic signed [DATA_W-1:0] mii_c;

  always_comb begin
    trace_c = A_W'(in_ch.data.m00) + A_W'(in_ch.data.m11) + A_W'(in_ch.data.m22);
    i_c     = 2'd0;
    mii_c   = in_ch.data.m00;
    if (in_ch.data.m11 > in_ch.data.m00) begin
      i_c   = 2'd1;
      mii_c = in_ch.data.m11;
    end
    if (in_ch.data.m22 > mii_c) i_c = 2'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m_r     <= in_ch.data;
      s1_trace_r <= trace_c;
      s1_i_r     <= i_c;
    end
  end

  // stage 2
  logic                  s2_valid_r;
  side_t                 s2_side_r;
  logic [RAD_W-1:0]      s2_rad_r;
  side_t                 side_c;
  logic signed [A_W-1:0] a_c;
  logic signed [A_W-1:0] one_c;
  logic signed [D_W-1:0] d_c [3];
  logic [RAD_W-1:0]      rad_c;
  in_data_t              m;

  always_comb begin
    m     = s1_m_r;
    one_c = A_W'(1) <<< FRAC;
    side_c = '0;
    if (s1_trace_r > 0) begin
      a_c = s1_trace_r + one_c;
      side_c.role = {ROLE_D2, ROLE_D1, ROLE_D0, ROLE_ROOT};
      d_c[0] = D_W'(m.m21) - D_W'(m.m12);
      d_c[1] = D_W'(m.m02) - D_W'(m.m20);
      d_c[2] = D_W'(m.m10) - D_W'(m.m01);
    end else begin
      case (s1_i_r)
        2'd1: begin
          a_c = A_W'(m.m11) - A_W'(m.m22) - A_W'(m.m00) + one_c;
          side_c.role = {ROLE_D1, ROLE_ROOT, ROLE_D2, ROLE_D0};
          d_c[0] = D_W'(m.m02) - D_W'(m.m20);
          d_c[1] = D_W'(m.m21) + D_W'(m.m12);
          d_c[2] = D_W'(m.m01) + D_W'(m.m10);
        end
        2'd2: begin
          a_c = A_W'(m.m22) - A_W'(m.m00) - A_W'(m.m11) + one_c;
          side_c.role = {ROLE_ROOT, ROLE_D2, ROLE_D1, ROLE_D0};
          d_c[0] = D_W'(m.m10) - D_W'(m.m01);
          d_c[1] = D_W'(m.m02) + D_W'(m.m20);
          d_c[2] = D_W'(m.m12) + D_W'(m.m21);
        end
        default: begin
          a_c = A_W'(m.m00) - A_W'(m.m11) - A_W'(m.m22) + one_c;
          side_c.role = {ROLE_D2, ROLE_D1, ROLE_ROOT, ROLE_D0};
          d_c[0] = D_W'(m.m21) - D_W'(m.m12);
          d_c[1] = D_W'(m.m10) + D_W'(m.m01);
          d_c[2] = D_W'(m.m20) + D_W'(m.m02);
        end
      endcase
    end
    side_c.degen = (s1_trace_r <= 0) && (a_c <= 0);
    for (int n = 0; n < 3; n++) begin
      side_c.neg[n] = d_c[n][D_W-1];
      side_c.mag[n] = d_c[n][D_W-1] ? MAG_W'(-d_c[n]) : MAG_W'(d_c[n]);
    end
    rad_c = side_c.degen ? '0 : (RAD_W'(unsigned'(a_c)) << FRAC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= side_c;
      s2_rad_r  <= rad_c;
    end
  end

  // root pipeline and matching side line
  logic [ROOT_W-1:0] root;
  logic              dl1_valid_r [SQRT_N];
  side_t             dl1_side_r  [SQRT_N];

  rmq_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (s2_rad_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < SQRT_N; n++) dl1_valid_r[n] <= 1'b0;
    end else if (adv) begin
      dl1_valid_r[0] <= s2_valid_r;
      for (int n = 1; n < SQRT_N; n++) dl1_valid_r[n] <= dl1_valid_r[n-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl1_side_r[0] <= s2_side_r;
      for (int n = 1; n < SQRT_N; n++) dl1_side_r[n] <= dl1_side_r[n-1];
    end
  end

  // stage 3: divider operands
  logic              s3_valid_r;
  side_t             s3_side_r;
  logic [ROOT_W-1:0] s3_rootc_r;
  logic [NUM_W-1:0]  s3_num_r [3];
  logic [DIV_W-1:0]  s3_div_r;
  logic [ROOT_W:0]   root_inc;

  assign root_inc = (ROOT_W+1)'(1) + (ROOT_W+1)'(root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= dl1_valid_r[SQRT_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r  <= dl1_side_r[SQRT_N-1];
      s3_rootc_r <= root_inc[ROOT_W:1];
      s3_div_r   <= {root, 1'b0};
      for (int n = 0; n < 3; n++) begin
        s3_num_r[n] <= (NUM_W'(dl1_side_r[SQRT_N-1].mag[n]) << FRAC) + NUM_W'(root);
      end
    end
  end

  // divider pipelines and matching side line
  logic [Q_W-1:0]    quo [3];
  logic              ovf [3];
  logic              dl2_valid_r [DIV_N];
  side_t             dl2_side_r  [DIV_N];
  logic [ROOT_W-1:0] dl2_rootc_r [DIV_N];

  for (genvar g = 0; g < 3; g++) begin : g_div
    rmq_div u_div (
      .clk (clk),
      .en  (adv),
      .num (s3_num_r[g]),
      .div (s3_div_r),
      .quo (quo[g]),
      .ovf (ovf[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < DIV_N; n++) dl2_valid_r[n] <= 1'b0;
    end else if (adv) begin
      dl2_valid_r[0] <= s3_valid_r;
      for (int n = 1; n < DIV_N; n++) dl2_valid_r[n] <= dl2_valid_r[n-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2_side_r[0]  <= s3_side_r;
      dl2_rootc_r[0] <= s3_rootc_r;
      for (int n = 1; n < DIV_N; n++) begin
        dl2_side_r[n]  <= dl2_side_r[n-1];
        dl2_rootc_r[n] <= dl2_rootc_r[n-1];
      end
    end
  end

  // output stage
  out_data_t                out_data_r;
  out_data_t                out_nxt;
  side_t                    so;
  logic signed [DATA_W-1:0] dq [3];
  logic signed [DATA_W-1:0] comp [4];

  always_comb begin
    so = dl2_side_r[DIV_N-1];
    for (int n = 0; n < 3; n++) dq[n] = sat_q(quo[n], ovf[n], so.neg[n]);
    for (int n = 0; n < 4; n++) begin
      case (so.role[n])
        ROLE_ROOT: comp[n] = signed'(dl2_rootc_r[DIV_N-1]);
        ROLE_D0:   comp[n] = dq[0];
        ROLE_D1:   comp[n] = dq[1];
        ROLE_D2:   comp[n] = dq[2];
        default:   comp[n] = '0;
      endcase
      if (so.degen) comp[n] = '0;
    end
    out_nxt.quat_w     = comp[0];
    out_nxt.quat_x     = comp[1];
    out_nxt.quat_y     = comp[2];
    out_nxt.quat_z     = comp[3];
    out_nxt.degenerate = so.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dl2_valid_r[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule
